/* hdl/firi8_pkg.sv */
// ----------------------------------------------------------------------------
// firi8_pkg
// Shared widths and constants for the signed 8-bit streaming FIR filter.
// ----------------------------------------------------------------------------
package firi8_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS  = 15;

  localparam int NUM_PAIRS  = 8;
  localparam int CFG_IDX_W  = $clog2(NUM_PAIRS);
  localparam int CFG_DATA_W = 2 * COEF_W;

  localparam int TAPS_DEFAULT = 16;
  localparam int TAPS_MAX     = 2 * NUM_PAIRS;

  localparam int SAMPLE_MAX = 127;
  localparam int SAMPLE_MIN = -128;

endpackage

/* hdl/fir_filter_int8.sv */
// ----------------------------------------------------------------------------
// fir_filter_int8
// Streaming direct-form FIR filter, signed 8-bit samples, Q1.15 coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed 8-bit sample per request, taken when in_valid is high
//           and in_stall is low.
//   out_* : one filtered sample per input request, in order, handed over
//           when out_valid is high and out_stall is low.
//   cfg_* : coefficient writes, register k holds tap 2k (bits 15:0) and tap
//           2k+1 (bits 31:16); cfg_ready is always high. Write only while idle.
// Throughput: one sample per clock while in_stall is low. A row of tap cells
//   shifts the delay line and registers the products, then a registered adder
//   tree of clog2(TAPS) levels sums them, then the output register.
// Stall: a pipeline level holds only while it is full and the one after it
//   holds, so bubbles close up; in_stall rises only once every level holds a
//   result and the receiver stalls.
// Reset: clears the sample history, the coefficients and all valid flags.
// ----------------------------------------------------------------------------
module fir_filter_int8 #(
  parameter int TAPS = firi8_pkg::TAPS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [firi8_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [firi8_pkg::SAMPLE_W-1:0]   out_sample_out,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [firi8_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [firi8_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import firi8_pkg::*;

  logic [CFG_DATA_W-1:0]    coef_pair_r [NUM_PAIRS];
  logic signed [SAMPLE_W-1:0] tap_sample [TAPS + 1];
  logic signed [PROD_W-1:0]   tap_product [TAPS];
  logic                       prod_vld_r;
  logic                       prod_ready;
  logic                       sum_ready;
  logic                       in_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        coef_pair_r[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      coef_pair_r[cfg_index] <= cfg_data;
    end
  end

  assign prod_ready = !prod_vld_r || sum_ready;
  assign in_stall   = !prod_ready;
  assign in_accept  = in_valid && prod_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (prod_ready) begin
      prod_vld_r <= in_valid;
    end
  end

  assign tap_sample[0] = in_sample_in;

  for (genvar j = 0; j < TAPS; j++) begin : g_tap
    logic signed [COEF_W-1:0] coef;
    assign coef = coef_pair_r[j / 2][(j % 2) * COEF_W +: COEF_W];

    firi8_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load_i    (in_accept),
      .sample_i  (tap_sample[j]),
      .coef_i    (coef),
      .sample_o  (tap_sample[j + 1]),
      .product_o (tap_product[j])
    );
  end

  firi8_sum #(
    .TAPS (TAPS)
  ) u_sum (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_i        (prod_vld_r),
    .ready_o        (sum_ready),
    .product_i      (tap_product),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

endmodule

/* hdl/firi8_cell.sv */
// ----------------------------------------------------------------------------
// firi8_cell
// One tap: holds one delayed sample, passes it on to the next tap and
// registers the tap product for the adder tree.
// ----------------------------------------------------------------------------
module firi8_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load_i,
  input  logic signed [firi8_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic signed [firi8_pkg::COEF_W-1:0]    coef_i,
  output logic signed [firi8_pkg::SAMPLE_W-1:0]  sample_o,
  output logic signed [firi8_pkg::PROD_W-1:0]    product_o
);
  import firi8_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [PROD_W-1:0]   product_r;
  logic signed [PROD_W-1:0]   product_nxt;

  assign product_nxt = coef_i * sample_i;

  // the delay line is filter state and clears at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (load_i) begin
      sample_r <= sample_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      product_r <= product_nxt;
    end
  end

  assign sample_o  = sample_r;
  assign product_o = product_r;

endmodule

/* hdl/firi8_sum.sv */
// ----------------------------------------------------------------------------
// firi8_sum
// Registered binary adder tree over the tap products, then scaling by 2^-15
// toward zero, saturation and the output register.
// ----------------------------------------------------------------------------
module firi8_sum #(
  parameter int TAPS = firi8_pkg::TAPS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [firi8_pkg::PROD_W-1:0]    product_i [TAPS],
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [firi8_pkg::SAMPLE_W-1:0]  out_sample_out
);
  import firi8_pkg::*;

  localparam int LVL    = $clog2(TAPS);
  localparam int LEAVES = 2 ** LVL;
  localparam int NODES  = LEAVES - 1;
  localparam int ACC_W  = PROD_W + LVL;

  localparam logic signed [ACC_W-1:0] TRUNC_ADJ = ACC_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [ACC_W-1:0] Q_MAX     = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] Q_MIN     = ACC_W'(SAMPLE_MIN);

  logic signed [ACC_W-1:0]    leaf [LEAVES];
  logic signed [ACC_W-1:0]    node_r [NODES];
  logic [LVL-1:0]             vld_r;
  logic [LVL-1:0]             rdy;
  logic                       rdy_out;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SAMPLE_W-1:0] out_sample_nxt;
  logic signed [ACC_W-1:0]    adj;
  logic signed [ACC_W-1:0]    quot;

  // leaves past the last tap read as zero
  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < TAPS) begin : g_used
      assign leaf[k] = ACC_W'(product_i[k]);
    end else begin : g_pad
      assign leaf[k] = '0;
    end
  end

  // heap layout: node i adds children 2i+1 and 2i+2, root is node 0
  for (genvar i = 0; i < NODES; i++) begin : g_node
    localparam int D  = $clog2(i + 2) - 1;
    localparam int CL = 2 * i + 1;
    if (CL >= NODES) begin : g_from_leaf
      always_ff @(posedge clk) begin
        if (rdy[D]) begin
          node_r[i] <= leaf[CL - NODES] + leaf[CL + 1 - NODES];
        end
      end
    end else begin : g_from_node
      always_ff @(posedge clk) begin
        if (rdy[D]) begin
          node_r[i] <= node_r[CL] + node_r[CL + 1];
        end
      end
    end
  end

  assign rdy_out = !out_valid_r || !out_stall;

  // a level moves when it is empty or the level after it moves
  always_comb begin
    logic prev;
    prev = rdy_out;
    for (int d = 0; d < LVL; d++) begin
      rdy[d] = !vld_r[d] || prev;
      prev   = rdy[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int d = 0; d < LVL; d++) begin
        if (rdy[d]) begin
          vld_r[d] <= (d == LVL - 1) ? valid_i : vld_r[(d + 1) % LVL];
        end
      end
    end
  end

  // divide by 2^15 toward zero: bias negative sums before the shift
  assign adj  = node_r[0] + (node_r[0][ACC_W-1] ? TRUNC_ADJ : '0);
  assign quot = adj >>> FRAC_BITS;

  always_comb begin
    if (quot > Q_MAX) begin
      out_sample_nxt = SAMPLE_W'(SAMPLE_MAX);
    end else if (quot < Q_MIN) begin
      out_sample_nxt = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      out_sample_nxt = quot[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign ready_o        = rdy[LVL-1];
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

/* hdl/firi8_checker.sv */
// ----------------------------------------------------------------------------
// firi8_checker
// Port-level checks for the FIR filter, bound onto the top level.
// ----------------------------------------------------------------------------
module firi8_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cfg_ready
);

  // a stalled result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input only backs up when the output is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // coefficient port never blocks
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid || !in_valid |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind fir_filter_int8 firi8_checker u_firi8_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .cfg_ready (cfg_ready)
);

/* tb/fir_result_check.sv */
// ----------------------------------------------------------------------------
// fir_result_check
// Watches the sample, result and coefficient channels of the FIR filter,
// predicts each filtered sample from its own copy of the taps and the delay
// line, and compares every result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module fir_result_check #(
  parameter int TAPS = firi8_pkg::TAPS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [firi8_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [firi8_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [firi8_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [firi8_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                    fail_count,
  output int                                    pending
);
  import firi8_pkg::*;

  logic signed [COEF_W-1:0]   tap_coef [TAPS_MAX];
  logic signed [SAMPLE_W-1:0] delay_line [TAPS-1];
  logic signed [SAMPLE_W-1:0] predicted_samples [$];
  int                         mismatches = 0;

  // exact sum of products, scaled toward zero, clipped, then the line shifts
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
    input logic signed [SAMPLE_W-1:0] x0
  );
    longint acc;
    longint scaled;
    acc = longint'(tap_coef[0]) * longint'(x0);
    for (int j = 1; j < TAPS; j++) begin
      acc += longint'(tap_coef[j]) * longint'(delay_line[j-1]);
    end
    scaled = acc / (longint'(1) <<< FRAC_BITS);
    if (scaled > longint'(SAMPLE_MAX)) scaled = longint'(SAMPLE_MAX);
    if (scaled < longint'(SAMPLE_MIN)) scaled = longint'(SAMPLE_MIN);
    for (int j = TAPS - 2; j > 0; j--) begin
      delay_line[j] = delay_line[j-1];
    end
    delay_line[0] = x0;
    return scaled[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      foreach (tap_coef[t]) tap_coef[t] = '0;
      foreach (delay_line[t]) delay_line[t] = '0;
      predicted_samples.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tap_coef[2 * int'(cfg_index)]     = cfg_data[COEF_W-1:0];
        tap_coef[2 * int'(cfg_index) + 1] = cfg_data[CFG_DATA_W-1:COEF_W];
      end
      // pop before push so a result can never match a request of the same edge
      if (out_valid && !out_stall) begin
        if (predicted_samples.size() == 0) begin
          $error("sample_out: expected no result, actual %0d", out_sample_out);
          mismatches++;
        end else begin
          want = predicted_samples.pop_front();
          if (out_sample_out !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, out_sample_out);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_samples.push_back(filter_sample(in_sample_in));
      end
    end
    fail_count <= mismatches;
    pending    <= predicted_samples.size();
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the signed 8-bit FIR filter: directed extremes of samples and
// coefficients, then random coefficient sets and samples under four patterns
// of sender gaps and receiver stalls. Checking is done by fir_result_check.
// ----------------------------------------------------------------------------
module testbench;
  import firi8_pkg::*;

  localparam int LATENCY = $clog2(TAPS_DEFAULT) + 1;

  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_sample_in = '0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_sample_out;
  logic                        cfg_valid    = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index    = '0;
  logic [CFG_DATA_W-1:0]       cfg_data     = '0;

  int                          fail_count;
  int                          pending;
  int                          sender_idle_pct    = 0;
  int                          receiver_stall_pct = 0;
  logic [CFG_DATA_W-1:0]       coef_set [NUM_PAIRS];

  fir_filter_int8 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  fir_result_check result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // valid stays high between back-to-back requests, drops only on a gap
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // drain the pipeline, then write all coefficient pairs from coef_set
  task automatic load_coef_set();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY) @(posedge clk);
    for (int k = 0; k < NUM_PAIRS; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= coef_set[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                          kind;
    logic [COEF_W-1:0]           tap;
    logic signed [SAMPLE_W-1:0]  value;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // tap 0 at -1.0: negation, 128 clips to 127
    coef_set    = '{default: '0};
    coef_set[0] = 32'h0000_8000;
    load_coef_set();
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(-1));
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(-2));

    // just under 1.0 and 0.5: fractional results truncate toward zero
    coef_set[0] = 32'h4000_7FFF;
    load_coef_set();
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample(SAMPLE_W'(-3));
    send_sample(SAMPLE_W'(3));

    // every tap at the positive extreme: sums clip both ways
    coef_set = '{default: 32'h7FFF_7FFF};
    load_coef_set();
    repeat (5) send_sample(SAMPLE_W'(SAMPLE_MAX));
    repeat (5) send_sample(SAMPLE_W'(SAMPLE_MIN));

    // every tap at -1.0
    coef_set = '{default: 32'h8000_8000};
    load_coef_set();
    repeat (2) send_sample(SAMPLE_W'(SAMPLE_MAX));
    repeat (2) send_sample(SAMPLE_W'(SAMPLE_MIN));

    for (int ph = 0; ph < 8; ph++) begin
      kind = (ph + ph / 4) % 4;
      for (int t = 0; t < TAPS_MAX; t++) begin
        case (kind)
          0: tap = COEF_W'($urandom);
          // small taps keep most sums inside the output range
          1: tap = COEF_W'(int'($urandom_range(4095)) - 2048);
          2: begin
            case ($urandom_range(2))
              0:       tap = 16'h7FFF;
              1:       tap = 16'h8000;
              default: tap = '0;
            endcase
          end
          default: tap = ($urandom_range(1) == 0) ? '0 : COEF_W'($urandom);
        endcase
        coef_set[t / 2][(t % 2) * COEF_W +: COEF_W] = tap;
      end
      load_coef_set();

      case (ph % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 60;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 60;
        end
        default: begin
          sender_idle_pct    = 29;
          receiver_stall_pct = 29;
        end
      endcase

      repeat (100) begin
        case ($urandom_range(15))
          0:       value = SAMPLE_W'(SAMPLE_MAX);
          1:       value = SAMPLE_W'(SAMPLE_MIN);
          2:       value = '0;
          3:       value = '1;
          default: value = SAMPLE_W'($urandom);
        endcase
        send_sample(value);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("[fir_filter_int8] OK");
    end else begin
      $display("[fir_filter_int8] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[fir_filter_int8] ERROR");
    $finish;
  end

endmodule
